>>> design/srlm_pkg.sv
package srlm_pkg;

	localparam int SAMPW = 16;
	localparam int GAINW = 10;
	localparam int GATEW = 16;
	localparam int CFGW  = 16;
	localparam int LVLW  = 16;
	localparam int BIW   = 4;
	localparam int FRAC  = 8;
	localparam int MAGW  = 24;          // |sample*256 - mean| < 2^24
	localparam int SQW   = 48;          // radicand width of the root unit
	localparam int SQH   = SQW / 2;     // root width

	localparam logic [16:0] ONE_Q15 = 17'd32768;

	localparam logic [GAINW-1:0] GAIN_RST = 10'd200;
	localparam logic [GATEW-1:0] GATE_RST = 16'd328;

	typedef enum logic {
		REG_GAIN = 1'b0,
		REG_GATE = 1'b1
	} reg_idx_t;

	typedef enum logic {
		OP_DIV  = 1'b0,
		OP_SQRT = 1'b1
	} ds_op_t;

	typedef struct packed {
		logic   go;
		ds_op_t op;
	} ds_req_t;

endpackage

>>> design/srlm_store.sv
module srlm_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [srlm_pkg::SAMPW-1:0] wdata,
	input  logic                              re,
	input  logic [AW-1:0]                     raddr,
	output logic signed [srlm_pkg::SAMPW-1:0] rdata
);

	logic signed [srlm_pkg::SAMPW-1:0] mem_q [DEPTH];
	logic signed [srlm_pkg::SAMPW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/srlm_divsqrt.sv
// Shared shift/subtract unit: restoring divide, one quotient bit a cycle,
// or digit-by-digit square root, one root bit a cycle.
module srlm_divsqrt #(
	parameter int DW = 59,
	parameter int CW = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srlm_pkg::ds_req_t            req,
	input  logic [DW-1:0]                dividend,
	input  logic [CW-1:0]                divisor,
	input  logic [srlm_pkg::SQW-1:0]     radicand,
	output logic                         done,
	output logic [DW-1:0]                quotient,
	output logic [srlm_pkg::SQH-1:0]     root
);

	localparam int SQH  = srlm_pkg::SQH;
	localparam int SQW  = srlm_pkg::SQW;
	localparam int PW   = (CW + 1 > SQH + 2) ? CW + 1 : SQH + 2;
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]     work_q;
	logic [PW-1:0]     part_q;
	logic [SQH-1:0]    root_q;
	logic [CW-1:0]     div_q;
	logic [CNTW-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	srlm_pkg::ds_op_t  op_q;

	logic [PW-1:0] trial_val;
	logic [PW-1:0] trial_sub;
	logic          ge;
	logic [PW-1:0] part_d;

	always_comb begin
		if (op_q == srlm_pkg::OP_SQRT) begin
			trial_val = PW'({part_q[SQH-1:0], work_q[DW-1 -: 2]});
			trial_sub = PW'({root_q, 2'b01});
		end else begin
			trial_val = PW'({part_q[CW-1:0], work_q[DW-1]});
			trial_sub = PW'(div_q);
		end
		ge     = (trial_val >= trial_sub);
		part_d = ge ? (trial_val - trial_sub) : trial_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				op_q   <= req.op;
				div_q  <= divisor;
				part_q <= '0;
				root_q <= '0;
				busy_q <= 1'b1;
				if (req.op == srlm_pkg::OP_SQRT) begin
					work_q <= {radicand, {(DW - SQW){1'b0}}};
					cnt_q  <= CNTW'(SQH);
				end else begin
					work_q <= dividend;
					cnt_q  <= CNTW'(DW);
				end
			end else if (busy_q) begin
				part_q <= part_d;
				if (op_q == srlm_pkg::OP_SQRT) begin
					work_q <= {work_q[DW-3:0], 2'b00};
					root_q <= {root_q[SQH-2:0], ge};
				end else begin
					work_q <= {work_q[DW-2:0], ge};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = work_q;
	assign root     = root_q;

endmodule

>>> design/segmented_rms_level_meter.sv
// Samples are taken one a cycle while busy is low; frame_end closes the frame.
// After frame_end busy stays high until the last band is out; the mean and each
// band's divide and roots go through the one shared divide/root unit. Results come one
// per band on strobe, unstoppable. Reset clears counters and levels and
// loads gain 200, gate 328; the sample memory is not cleared.
module segmented_rms_level_meter #(
	parameter int BANDS       = 16,
	parameter int FRAME_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [srlm_pkg::SAMPW-1:0] sample,
	input  logic                              frame_end,
	input  logic                              cfg_we,
	input  logic [0:0]                        cfg_index,
	input  logic [srlm_pkg::CFGW-1:0]         cfg_data,
	output logic                              strobe,
	output logic [srlm_pkg::BIW-1:0]          band_index,
	output logic [srlm_pkg::LVLW-1:0]         level,
	output logic                              last_band
);

	localparam int CW    = $clog2(FRAME_DEPTH + 1);
	localparam int AW    = $clog2(FRAME_DEPTH);
	localparam int BW    = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int SUMW  = srlm_pkg::SAMPW + CW;
	localparam int MAGW  = srlm_pkg::MAGW;
	localparam int ACCW  = 2 * MAGW + CW;
	localparam int MEANW = MAGW + 1;
	localparam int DEVW  = MAGW + 2;
	localparam int SQW   = srlm_pkg::SQW;
	localparam int SQH   = srlm_pkg::SQH;
	localparam int GAINW = srlm_pkg::GAINW;
	localparam int GATEW = srlm_pkg::GATEW;
	localparam int LVLW  = srlm_pkg::LVLW;
	localparam int FRAC  = srlm_pkg::FRAC;
	localparam int PRODW = GAINW + SQH;
	localparam int VALW  = PRODW - FRAC;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHORT,
		ST_MEAN,
		ST_MEAN_W,
		ST_BAND,
		ST_ACC,
		ST_DIVLEN_W,
		ST_SQ1_W,
		ST_SCALE,
		ST_GATE,
		ST_SQ2_W,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [GAINW-1:0]        gain_q;
	logic [GATEW-1:0]        gate_q;
	logic [CW-1:0]           count_q;
	logic signed [SUMW-1:0]  sum_q;
	logic signed [MEANW-1:0] mean_q;
	logic [CW-1:0]           per_q;
	logic [BW-1:0]           phase_q;
	logic [CW-1:0]           ptr_q;
	logic [CW-1:0]           end_q;
	logic [CW-1:0]           len_q;
	logic [BW-1:0]           band_q;
	logic [SQH-1:0]          seg_q;
	logic [PRODW-1:0]        prod_q;
	logic [16:0]             cur_q;
	logic [LVLW-1:0]         levels_q [BANDS];

	logic                    strobe_q;
	logic [srlm_pkg::BIW-1:0] band_index_q;
	logic [LVLW-1:0]         level_q;
	logic                    last_band_q;

	srlm_pkg::ds_req_t       ds_req_q;
	logic [ACCW-1:0]         ds_dividend_q;
	logic [CW-1:0]           ds_divisor_q;
	logic [SQW-1:0]          ds_radicand_q;
	logic                    ds_done;
	logic [ACCW-1:0]         ds_quot;
	logic [SQH-1:0]          ds_root;

	// accumulation pipeline
	logic                    rd_v_s1, rd_v_s2, rd_v_s3;
	logic [MAGW-1:0]         mag_s2;
	logic [2*MAGW-1:0]       sq_s3;
	logic [ACCW-1:0]         acc_q;

	logic                    take;
	logic                    room;
	logic [CW-1:0]           count_d;
	logic                    issue;
	logic                    band_last;
	logic [SUMW-1:0]         sum_mag;
	logic signed [srlm_pkg::SAMPW-1:0] rd_data;
	logic signed [DEVW-1:0]  dev;
	logic [DEVW-1:0]         dev_mag;
	logic [VALW-1:0]         value;
	logic [16:0]             clamp;
	logic [LVLW+1:0]         lvl_sum;

	assign busy      = (state_q != ST_IDLE);
	assign take      = start && !busy;
	assign room      = (count_q < CW'(FRAME_DEPTH));
	assign count_d   = room ? count_q + 1'b1 : count_q;
	assign issue     = (state_q == ST_ACC) && (ptr_q != end_q);
	assign band_last = (band_q == BW'(BANDS - 1));
	assign sum_mag   = sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
	assign dev       = (DEVW'(rd_data) <<< FRAC) - DEVW'(mean_q);
	assign dev_mag   = dev[DEVW-1] ? DEVW'(-dev) : DEVW'(dev);
	assign value     = prod_q[PRODW-1:FRAC];
	assign clamp     = (value > VALW'(srlm_pkg::ONE_Q15)) ? srlm_pkg::ONE_Q15 : value[16:0];
	assign lvl_sum   = (LVLW+2)'(levels_q[band_q]) + (LVLW+2)'(cur_q);

	srlm_store #(
		.DEPTH (FRAME_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (take && room),
		.waddr (count_q[AW-1:0]),
		.wdata (sample),
		.re    (issue),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rd_data)
	);

	srlm_divsqrt #(
		.DW (ACCW),
		.CW (CW)
	) u_divsqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ds_req_q),
		.dividend (ds_dividend_q),
		.divisor  (ds_divisor_q),
		.radicand (ds_radicand_q),
		.done     (ds_done),
		.quotient (ds_quot),
		.root     (ds_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= srlm_pkg::GAIN_RST;
			gate_q <= srlm_pkg::GATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				srlm_pkg::REG_GAIN: gain_q <= cfg_data[GAINW-1:0];
				srlm_pkg::REG_GATE: gate_q <= cfg_data[GATEW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			rd_v_s2 <= 1'b0;
			rd_v_s3 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			rd_v_s2 <= rd_v_s1;
			rd_v_s3 <= rd_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= dev_mag[MAGW-1:0];
		sq_s3  <= mag_s2 * mag_s2;
		if (state_q == ST_BAND) begin
			acc_q <= '0;
		end else if (rd_v_s3) begin
			acc_q <= acc_q + ACCW'(sq_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			per_q       <= '0;
			phase_q     <= '0;
			band_q      <= '0;
			ptr_q       <= '0;
			levels_q    <= '{default: '0};
			strobe_q    <= 1'b0;
			last_band_q <= 1'b0;
			ds_req_q    <= '{go: 1'b0, op: srlm_pkg::OP_DIV};
		end else begin
			strobe_q    <= 1'b0;
			ds_req_q.go <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						count_q <= count_d;
						if (room) begin
							sum_q <= sum_q + SUMW'(sample);
							// segment length n / BANDS kept as samples arrive
							if (phase_q == BW'(BANDS - 1)) begin
								phase_q <= '0;
								per_q   <= per_q + 1'b1;
							end else begin
								phase_q <= phase_q + 1'b1;
							end
						end
						if (frame_end) begin
							band_q  <= '0;
							state_q <= (count_d < CW'(BANDS)) ? ST_SHORT : ST_MEAN;
						end
					end
				end
				ST_SHORT: begin
					strobe_q     <= 1'b1;
					band_index_q <= srlm_pkg::BIW'(band_q);
					level_q      <= '0;
					last_band_q  <= band_last;
					if (band_last) begin
						count_q <= '0;
						sum_q   <= '0;
						per_q   <= '0;
						phase_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						band_q <= band_q + 1'b1;
					end
				end
				ST_MEAN: begin
					// rounded mean: (|sum|*256 + n/2) / n
					ds_req_q      <= '{go: 1'b1, op: srlm_pkg::OP_DIV};
					ds_dividend_q <= ACCW'({sum_mag, {FRAC{1'b0}}}) + ACCW'(count_q >> 1);
					ds_divisor_q  <= count_q;
					state_q       <= ST_MEAN_W;
				end
				ST_MEAN_W: begin
					if (ds_done) begin
						mean_q  <= sum_q[SUMW-1] ? -$signed({1'b0, ds_quot[MAGW-1:0]})
						                         :  $signed({1'b0, ds_quot[MAGW-1:0]});
						ptr_q   <= '0;
						state_q <= ST_BAND;
					end
				end
				ST_BAND: begin
					// last band runs to the frame end and takes the remainder
					end_q   <= band_last ? count_q : ptr_q + per_q;
					len_q   <= band_last ? count_q - ptr_q : per_q;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (!rd_v_s1 && !rd_v_s2 && !rd_v_s3) begin
						ds_req_q      <= '{go: 1'b1, op: srlm_pkg::OP_DIV};
						ds_dividend_q <= acc_q;
						ds_divisor_q  <= len_q;
						state_q       <= ST_DIVLEN_W;
					end
				end
				ST_DIVLEN_W: begin
					if (ds_done) begin
						ds_req_q      <= '{go: 1'b1, op: srlm_pkg::OP_SQRT};
						ds_radicand_q <= ds_quot[SQW-1:0];
						state_q       <= ST_SQ1_W;
					end
				end
				ST_SQ1_W: begin
					if (ds_done) begin
						seg_q   <= ds_root;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					prod_q  <= PRODW'(gain_q) * PRODW'(seg_q);
					state_q <= ST_GATE;
				end
				ST_GATE: begin
					if (value < VALW'(gate_q)) begin
						cur_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						ds_req_q      <= '{go: 1'b1, op: srlm_pkg::OP_SQRT};
						ds_radicand_q <= SQW'({clamp, 15'b0});
						state_q       <= ST_SQ2_W;
					end
				end
				ST_SQ2_W: begin
					if (ds_done) begin
						cur_q   <= ds_root[16:0];
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					levels_q[band_q] <= lvl_sum[LVLW:1];
					strobe_q         <= 1'b1;
					band_index_q     <= srlm_pkg::BIW'(band_q);
					level_q          <= lvl_sum[LVLW:1];
					last_band_q      <= band_last;
					if (band_last) begin
						count_q <= '0;
						sum_q   <= '0;
						per_q   <= '0;
						phase_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						band_q  <= band_q + 1'b1;
						state_q <= ST_BAND;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe     = strobe_q;
	assign band_index = band_index_q;
	assign level      = level_q;
	assign last_band  = last_band_q;

endmodule

>>> test/testbench.sv
module testbench;

	localparam int BANDS       = 16;
	localparam int FRAME_DEPTH = 1024;
	localparam int PHASE_BEATS = 40;
	localparam int DRAIN       = 64;
	localparam int CYCLE_LIMIT = 1000000;

	typedef enum {FULL_SCALE, NOISY, CONSTANT} shape_t;

	typedef struct {
		logic signed [srlm_pkg::SAMPW-1:0] smp;
		logic                              fin;
	} beat_t;

	typedef struct {
		logic [srlm_pkg::BIW-1:0]  band;
		logic [srlm_pkg::LVLW-1:0] lvl;
		logic                      last;
	} band_report_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              start     = 1'b0;
	logic signed [srlm_pkg::SAMPW-1:0] sample    = '0;
	logic                              frame_end = 1'b0;
	logic                              cfg_we    = 1'b0;
	logic [0:0]                        cfg_index = srlm_pkg::REG_GAIN;
	logic [srlm_pkg::CFGW-1:0]         cfg_data  = '0;
	logic                              busy;
	logic                              strobe;
	logic [srlm_pkg::BIW-1:0]          band_index;
	logic [srlm_pkg::LVLW-1:0]         level;
	logic                              last_band;

	beat_t        sample_beats[$];
	band_report_t expected_bands[$];
	longint       frame_samples[$];
	longint       frame_total = 0;
	longint       band_level[BANDS] = '{default: 0};
	longint       meter_gain = srlm_pkg::GAIN_RST;
	longint       meter_gate = srlm_pkg::GATE_RST;
	int           mismatches = 0;
	int           cycles = 0;
	int           burst_left = 0;
	int           gap_left = 0;

	segmented_rms_level_meter #(.BANDS(BANDS), .FRAME_DEPTH(FRAME_DEPTH)) dut (
		.clk, .arst_n, .start, .busy, .sample, .frame_end,
		.cfg_we, .cfg_index, .cfg_data,
		.strobe, .band_index, .level, .last_band
	);

	initial forever #5 clk = ~clk;

	function automatic longint int_root(longint x);
		longint r = 0;
		longint cand;
		for (int i = 30; i >= 0; i--) begin
			cand = r | (longint'(1) << i);
			if (cand * cand <= x)
				r = cand;
		end
		return r;
	endfunction

	// gated, root-mapped level of one time segment, mean already in Q8
	function automatic longint segment_level(int first, int stop, longint mean);
		longint acc = 0;
		longint dev, rms, scaled;
		for (int i = first; i < stop; i++) begin
			dev = frame_samples[i] * 256 - mean;
			acc += dev * dev;
		end
		rms = int_root(acc / (stop - first));
		scaled = (meter_gain * rms) >>> 8;
		if (scaled < meter_gate)
			return 0;
		if (scaled > 32768)
			scaled = 32768;
		return int_root(scaled << 15);
	endfunction

	function automatic void predict_beat(beat_t bt);
		longint n, num, q, mean, cur, lvl;
		int per, stop;
		band_report_t rep;
		mean = 0;
		per = 0;
		if (frame_samples.size() < FRAME_DEPTH) begin
			frame_samples.push_back(bt.smp);
			frame_total += bt.smp;
		end
		if (!bt.fin)
			return;
		n = frame_samples.size();
		if (n >= BANDS) begin
			num = frame_total * 256;
			q = ((num < 0 ? -num : num) + n / 2) / n;
			mean = num < 0 ? -q : q;
			per = int'(n) / BANDS;
		end
		for (int k = 0; k < BANDS; k++) begin
			lvl = 0;
			// short frame: zeros out, stored levels left alone
			if (n >= BANDS) begin
				stop = (k == BANDS - 1) ? int'(n) : (k + 1) * per;
				cur = segment_level(k * per, stop, mean);
				lvl = (band_level[k] + cur) >> 1;
				band_level[k] = lvl;
			end
			rep.band = k[srlm_pkg::BIW-1:0];
			rep.lvl = lvl[srlm_pkg::LVLW-1:0];
			rep.last = (k == BANDS - 1);
			expected_bands.push_back(rep);
		end
		frame_samples.delete();
		frame_total = 0;
	endfunction

	task automatic queue_frame(int len, shape_t shape);
		beat_t bt;
		int amp, dc, v;
		amp = 1 << $urandom_range(0, 15);
		dc = int'($urandom_range(0, 65535)) - 32768;
		dc = dc >>> $urandom_range(0, 15);
		for (int i = 0; i < len; i++) begin
			case (shape)
			FULL_SCALE: v = int'($urandom_range(0, 65535)) - 32768;
			NOISY:      v = dc + int'($urandom_range(0, 2 * amp)) - amp;
			default:    v = dc;
			endcase
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			bt.smp = v[srlm_pkg::SAMPW-1:0];
			bt.fin = (i == len - 1);
			sample_beats.push_back(bt);
		end
	endtask

	task automatic queue_random_frames(int beats);
		int len, pick;
		shape_t shape;
		while (beats > 0) begin
			if ($urandom_range(0, 7) == 0)
				len = $urandom_range(1, BANDS - 1);
			else
				len = $urandom_range(BANDS, 80);
			pick = $urandom_range(0, 5);
			shape = (pick == 0) ? FULL_SCALE : (pick == 1) ? CONSTANT : NOISY;
			queue_frame(len, shape);
			beats -= len;
		end
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (sample_beats.size() != 0 || start || expected_bands.size() != 0 || busy);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(srlm_pkg::reg_idx_t idx, logic [srlm_pkg::CFGW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == srlm_pkg::REG_GAIN)
			meter_gain = val[srlm_pkg::GAINW-1:0];
		else
			meter_gate = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sample beats, sent in bursts with random gaps
	always @(posedge clk) begin
		beat_t taken;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				taken = sample_beats.pop_front();
				predict_beat(taken);
			end
			// a beat offered while busy is held as it is
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (sample_beats.size() > 0) begin
					start <= 1'b1;
					sample <= sample_beats[0].smp;
					frame_end <= sample_beats[0].fin;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		band_report_t want;
		if (arst_n && strobe) begin
			if (expected_bands.size() == 0) begin
				$error("band result %0d with none expected", band_index);
				mismatches++;
			end else begin
				want = expected_bands.pop_front();
				if (band_index !== want.band) begin
					$error("band_index: expected %0d, got %0d", want.band, band_index);
					mismatches++;
				end
				if (level !== want.lvl) begin
					$error("level: expected %0d, got %0d (band %0d)", want.lvl, level, want.band);
					mismatches++;
				end
				if (last_band !== want.last) begin
					$error("last_band: expected %0d, got %0d", want.last, last_band);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// single-sample short frames around a 16-sample full-swing frame
		sample_beats.push_back(beat_t'{16'sh7FFF, 1'b1});
		for (int i = 0; i < BANDS; i++)
			sample_beats.push_back(beat_t'{i[0] ? 16'sh8000 : 16'sh7FFF, i == BANDS - 1});
		sample_beats.push_back(beat_t'{16'sh8000, 1'b1});
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		write_reg(srlm_pkg::REG_GAIN, 16'd1023);
		write_reg(srlm_pkg::REG_GATE, 16'd0);
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		// zero gain with open gate, junk above the gain field
		write_reg(srlm_pkg::REG_GAIN, {6'($urandom), 10'd0});
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		write_reg(srlm_pkg::REG_GATE, srlm_pkg::GATE_RST);
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		write_reg(srlm_pkg::REG_GAIN, 16'd1);
		write_reg(srlm_pkg::REG_GATE, 16'd1);
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		write_reg(srlm_pkg::REG_GAIN, 16'd1023);
		write_reg(srlm_pkg::REG_GATE, srlm_pkg::ONE_Q15[srlm_pkg::CFGW-1:0]);
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		// gate above one
		write_reg(srlm_pkg::REG_GAIN, 16'($urandom));
		write_reg(srlm_pkg::REG_GATE, 16'hFFFF);
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		write_reg(srlm_pkg::REG_GAIN, 16'($urandom_range(1, 1023)));
		write_reg(srlm_pkg::REG_GATE, 16'($urandom_range(0, 600)));
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		// overfull frame: beats past the store are dropped, frame_end still counts
		write_reg(srlm_pkg::REG_GAIN, srlm_pkg::GAIN_RST);
		write_reg(srlm_pkg::REG_GATE, srlm_pkg::GATE_RST);
		queue_frame(FRAME_DEPTH + $urandom_range(1, 8), NOISY);
		queue_random_frames(PHASE_BEATS);
		wait_idle();

		if (mismatches == 0 && expected_bands.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
